[hdl/zsc_pkg.sv]
// ----------------------------------------------------------------------------
// Zero suppression and calibration package
// Shared constants, codes and types of the zero suppression block.
// ----------------------------------------------------------------------------
package zsc_pkg;

  localparam int DETECTORS = 4;
  localparam int STRIPS    = 16;
  localparam int CRYSTALS  = 9;
  localparam int LAYERS    = 4;

  localparam int ADDR_W   = 8;
  localparam int ADC_W    = 12;
  localparam int CUT_W    = 12;
  localparam int SLOPE_W  = 20;
  localparam int ICPT_W   = 32;
  localparam int PROD_W   = 32;
  localparam int ENERGY_W = 34;
  localparam int DCNT_W   = 5;
  localparam int ECNT_W   = 7;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_HIT = 2'd0,
    KIND_DET = 2'd1,
    KIND_EVT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    LAYER_FIRST  = 2'd0,
    LAYER_FRONT  = 2'd1,
    LAYER_BACK   = 2'd2,
    LAYER_SCINT  = 2'd3
  } layer_t;

  typedef struct packed {
    logic [ICPT_W-1:0]  intercept;
    logic [SLOPE_W-1:0] slope;
    logic [CUT_W-1:0]   cut;
  } calib_t;

  typedef struct packed {
    logic                          hit;
    logic                          det_res;
    logic                          evt_res;
    logic [1:0]                    detector;
    logic [1:0]                    layer;
    logic [3:0]                    channel;
    logic [ENERGY_W-1:0]           energy;
    logic [LAYERS-1:0][ECNT_W-1:0] det_counts;
    logic [LAYERS-1:0][ECNT_W-1:0] evt_counts;
  } bundle_t;

endpackage

[hdl/zsc_calib.sv]
// ----------------------------------------------------------------------------
// Calibration store
// One write port and one registered read port over the per-channel entries.
// ----------------------------------------------------------------------------
module zsc_calib (
  input  logic                        clk,
  input  logic                        we,
  input  logic [zsc_pkg::ADDR_W-1:0]  waddr,
  input  zsc_pkg::calib_t             wdata,
  input  logic                        re,
  input  logic [zsc_pkg::ADDR_W-1:0]  raddr,
  output zsc_pkg::calib_t             rdata
);
  import zsc_pkg::*;

  calib_t mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/zsc_emit.sv]
// ----------------------------------------------------------------------------
// Result emitter
// Holds the results of one sample and sends them out one item at a time.
// ----------------------------------------------------------------------------
module zsc_emit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        bundle_valid,
  input  zsc_pkg::bundle_t            bundle,
  output logic                        bundle_ready,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [1:0]                  kind,
  output logic [1:0]                  hit_detector,
  output logic [1:0]                  hit_layer,
  output logic [3:0]                  hit_channel,
  output logic signed [zsc_pkg::ENERGY_W-1:0] energy,
  output logic [zsc_pkg::ECNT_W-1:0]  count_first_layer,
  output logic [zsc_pkg::ECNT_W-1:0]  count_second_front,
  output logic [zsc_pkg::ECNT_W-1:0]  count_second_back,
  output logic [zsc_pkg::ECNT_W-1:0]  count_scintillator,
  output logic                        last_result
);
  import zsc_pkg::*;

  logic    pend_hit;
  logic    pend_det;
  logic    pend_evt;
  bundle_t held;
  logic    fire;
  logic [LAYERS-1:0][ECNT_W-1:0] counts;

  assign result_valid = pend_hit | pend_det | pend_evt;
  assign fire         = result_valid & result_ready;
  assign bundle_ready = !result_valid || (fire && last_result);

  always_comb begin
    kind         = KIND_EVT;
    hit_detector = 2'd0;
    hit_layer    = 2'd0;
    hit_channel  = 4'd0;
    energy       = '0;
    counts       = held.evt_counts;
    last_result  = 1'b1;
    if (pend_hit) begin
      kind         = KIND_HIT;
      hit_detector = held.detector;
      hit_layer    = held.layer;
      hit_channel  = held.channel;
      energy       = held.energy;
      counts       = '0;
      last_result  = !(pend_det || pend_evt);
    end else if (pend_det) begin
      kind         = KIND_DET;
      hit_detector = held.detector;
      counts       = held.det_counts;
      last_result  = !pend_evt;
    end
  end

  assign count_first_layer  = counts[0];
  assign count_second_front = counts[1];
  assign count_second_back  = counts[2];
  assign count_scintillator = counts[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_hit <= 1'b0;
      pend_det <= 1'b0;
      pend_evt <= 1'b0;
    end else if (bundle_valid && bundle_ready) begin
      pend_hit <= bundle.hit;
      pend_det <= bundle.det_res;
      pend_evt <= bundle.evt_res;
    end else if (fire) begin
      if (pend_hit) begin
        pend_hit <= 1'b0;
      end else if (pend_det) begin
        pend_det <= 1'b0;
      end else begin
        pend_evt <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bundle_valid && bundle_ready) begin
      held <= bundle;
    end
  end

endmodule

[hdl/detector_zero_suppress_calibrate_core.sv]
// ----------------------------------------------------------------------------
// Detector zero suppression and calibration core
// Suppresses channels at or below threshold, calibrates strip energies and counts
// firings per layer for each detector and each event.
// ----------------------------------------------------------------------------
// Usage:
// The sample channel takes one item per cycle while sample_ready is high.
// Operation load writes the calibration entry of (detector, layer, channel)
// and produces no result; every entry must be loaded before a sample reads
// it. Operation sample reads the entry from the calibration RAM, compares
// against the threshold and, on strip layers, multiplies slope by ADC value
// and adds the intercept (scintillator energy is the raw ADC value), passing
// the read stage (RAM read and multiply) and the add stage (add and count
// update). While the receiver is ready and each item causes at most one
// result, one item per cycle is taken; an item causing several results holds
// the result port until all are sent, as the result channel moves at most one
// item per cycle. Reset clears the pipeline and both counter sets; the
// calibration RAM keeps its contents and is not cleared. When the receiver
// stalls, the pipeline fills and sample_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module detector_zero_suppress_calibrate_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  logic                        operation,
  input  logic [1:0]                  detector,
  input  logic [1:0]                  layer,
  input  logic [3:0]                  channel,
  input  logic [zsc_pkg::ADC_W-1:0]   adc_value,
  input  logic [zsc_pkg::CUT_W-1:0]   cut_value,
  input  logic [zsc_pkg::SLOPE_W-1:0] slope_value,
  input  logic signed [zsc_pkg::ICPT_W-1:0] intercept_value,
  input  logic                        detector_last,
  input  logic                        event_last,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [1:0]                  kind,
  output logic [1:0]                  hit_detector,
  output logic [1:0]                  hit_layer,
  output logic [3:0]                  hit_channel,
  output logic signed [zsc_pkg::ENERGY_W-1:0] energy,
  output logic [zsc_pkg::ECNT_W-1:0]  count_first_layer,
  output logic [zsc_pkg::ECNT_W-1:0]  count_second_front,
  output logic [zsc_pkg::ECNT_W-1:0]  count_second_back,
  output logic [zsc_pkg::ECNT_W-1:0]  count_scintillator,
  output logic                        last_result
);
  import zsc_pkg::*;

  logic              accept;
  logic              is_sample;
  logic [ADDR_W-1:0] addr;
  calib_t            wentry;
  calib_t            rentry;
  logic              in_range;

  // Stage 1: calibration entry being read.
  logic             v1;
  logic [1:0]       det1;
  logic [1:0]       lay1;
  logic [3:0]       ch1;
  logic [ADC_W-1:0] adc1;
  logic             ok1;
  logic             dl1;
  logic             el1;
  logic             fire1;
  logic [PROD_W-1:0] prod_next;
  logic             adv1;
  logic             free1;

  // Stage 2: product registered, intercept added, counts updated.
  logic              v2;
  logic              fire2;
  logic [1:0]        det2;
  logic [1:0]        lay2;
  logic [3:0]        ch2;
  logic [ADC_W-1:0]  adc2;
  logic [PROD_W-1:0] prod2;
  logic [ICPT_W-1:0] icpt2;
  logic              dl2;
  logic              el2;
  logic              has_res;
  logic              adv2;
  logic              free2;

  logic [LAYERS-1:0][DCNT_W-1:0] det_counts;
  logic [LAYERS-1:0][ECNT_W-1:0] evt_counts;
  logic [LAYERS-1:0][DCNT_W-1:0] det_counts_next;
  logic [LAYERS-1:0][ECNT_W-1:0] evt_counts_next;

  bundle_t bundle;
  logic    bundle_ready;

  assign accept    = sample_valid & sample_ready;
  assign is_sample = (operation == OP_SAMPLE);
  assign addr      = {detector, layer, channel};
  assign wentry    = '{intercept: intercept_value, slope: slope_value, cut: cut_value};
  assign in_range  = (int'(detector) < DETECTORS) &&
                     ((layer == LAYER_SCINT) ? (int'(channel) < CRYSTALS)
                                             : (int'(channel) < STRIPS));

  zsc_calib u_calib (
    .clk   (clk),
    .we    (accept && !is_sample),
    .waddr (addr),
    .wdata (wentry),
    .re    (accept && is_sample),
    .raddr (addr),
    .rdata (rentry)
  );

  assign has_res      = fire2 | dl2 | el2;
  assign adv2         = v2 && (!has_res || bundle_ready);
  assign free2        = !v2 || adv2;
  assign adv1         = v1 && free2;
  assign free1        = !v1 || adv1;
  assign sample_ready = free1;

  assign fire1     = ok1 && (adc1 > rentry.cut);
  assign prod_next = PROD_W'(rentry.slope) * PROD_W'(adc1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (free1) begin
        v1 <= accept && is_sample;
      end
      if (free2) begin
        v2 <= adv1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_sample) begin
      det1 <= detector;
      lay1 <= layer;
      ch1  <= channel;
      adc1 <= adc_value;
      ok1  <= in_range;
      dl1  <= detector_last;
      el1  <= event_last;
    end
    if (adv1) begin
      fire2 <= fire1;
      det2  <= det1;
      lay2  <= lay1;
      ch2   <= ch1;
      adc2  <= adc1;
      prod2 <= prod_next;
      icpt2 <= rentry.intercept;
      dl2   <= dl1;
      el2   <= el1;
    end
  end

  // The product is below 2^32 and the intercept is 32-bit signed, so the
  // 34-bit sum never leaves the signed range.
  always_comb begin
    bundle.hit      = fire2;
    bundle.det_res  = dl2;
    bundle.evt_res  = el2;
    bundle.detector = det2;
    bundle.layer    = lay2;
    bundle.channel  = ch2;
    if (lay2 == LAYER_SCINT) begin
      bundle.energy = ENERGY_W'(adc2);
    end else begin
      bundle.energy = {2'b00, prod2} + {{(ENERGY_W - ICPT_W){icpt2[ICPT_W-1]}}, icpt2};
    end
    for (int l = 0; l < LAYERS; l++) begin
      det_counts_next[l] = det_counts[l];
      evt_counts_next[l] = evt_counts[l];
      if (fire2 && (int'(lay2) == l)) begin
        if (det_counts[l] != {DCNT_W{1'b1}}) begin
          det_counts_next[l] = det_counts[l] + 1'b1;
        end
        if (evt_counts[l] != {ECNT_W{1'b1}}) begin
          evt_counts_next[l] = evt_counts[l] + 1'b1;
        end
      end
      bundle.det_counts[l] = ECNT_W'(det_counts_next[l]);
      bundle.evt_counts[l] = evt_counts_next[l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      det_counts <= '0;
      evt_counts <= '0;
    end else if (adv2) begin
      det_counts <= (dl2 || el2) ? '0 : det_counts_next;
      evt_counts <= el2 ? '0 : evt_counts_next;
    end
  end

  zsc_emit u_emit (
    .clk                (clk),
    .rst                (rst),
    .bundle_valid       (v2 && has_res),
    .bundle             (bundle),
    .bundle_ready       (bundle_ready),
    .result_valid       (result_valid),
    .result_ready       (result_ready),
    .kind               (kind),
    .hit_detector       (hit_detector),
    .hit_layer          (hit_layer),
    .hit_channel        (hit_channel),
    .energy             (energy),
    .count_first_layer  (count_first_layer),
    .count_second_front (count_second_front),
    .count_second_back  (count_second_back),
    .count_scintillator (count_scintillator),
    .last_result        (last_result)
  );

  a_sample_enters: assert property (@(posedge clk) disable iff (rst)
    accept && is_sample |=> v1)
    else $error("accepted sample did not enter the read stage");

  a_load_no_entry: assert property (@(posedge clk) disable iff (rst)
    accept && !is_sample && !v1 |=> !v1)
    else $error("calibration load entered the pipeline");

  a_det_count_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_DET |->
      count_first_layer <= 7'd31 && count_second_front <= 7'd31 &&
      count_second_back <= 7'd31 && count_scintillator <= 7'd31)
    else $error("detector count beyond saturation");

  a_evt_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_EVT |-> last_result)
    else $error("event totals not marked last");

endmodule

[verif/detector_zero_suppress_calibrate_core_tb.sv]
// ----------------------------------------------------------------------------
// Zero suppression and calibration core testbench
// Loads calibration entries and streams readout samples through the core.
// Every accepted item is run through a behavioral copy of the threshold,
// calibration and per-layer counting logic. Each result taken from the core
// is compared field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module detector_zero_suppress_calibrate_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zsc_pkg::*;

  localparam int     IDLE_PCT        = 28;
  localparam int     HOLD_OFF_CYCLES = 80;
  localparam int     WATCHDOG_LIMIT  = 2000;
  localparam int     RANDOM_ITEMS    = 50;
  localparam int     SETTLE_CYCLES   = 12;
  localparam int     DCNT_MAX        = (1 << DCNT_W) - 1;
  localparam int     ECNT_MAX        = (1 << ECNT_W) - 1;
  localparam longint E_MAX           = 64'sd8589934591;
  localparam longint E_MIN           = -64'sd8589934592;

  typedef struct {
    op_t                op;
    logic [1:0]         det;
    layer_t             layer;
    logic [3:0]         channel;
    logic [ADC_W-1:0]   adc;
    logic [CUT_W-1:0]   cut;
    logic [SLOPE_W-1:0] slope;
    logic [ICPT_W-1:0]  icpt;
    logic               det_last;
    logic               evt_last;
  } sample_item_t;

  typedef struct {
    kind_t                         kind;
    logic [1:0]                    det;
    logic [1:0]                    layer;
    logic [3:0]                    channel;
    logic signed [ENERGY_W-1:0]    energy;
    logic [LAYERS-1:0][ECNT_W-1:0] counts;
    logic                          last;
  } zs_result_t;

  logic                       clk;
  logic                       rst;
  logic                       sample_valid;
  logic                       sample_ready;
  logic                       operation;
  logic [1:0]                 detector;
  logic [1:0]                 layer;
  logic [3:0]                 channel;
  logic [ADC_W-1:0]           adc_value;
  logic [CUT_W-1:0]           cut_value;
  logic [SLOPE_W-1:0]         slope_value;
  logic signed [ICPT_W-1:0]   intercept_value;
  logic                       detector_last;
  logic                       event_last;
  logic                       result_valid;
  logic                       result_ready;
  logic [1:0]                 kind;
  logic [1:0]                 hit_detector;
  logic [1:0]                 hit_layer;
  logic [3:0]                 hit_channel;
  logic signed [ENERGY_W-1:0] energy;
  logic [ECNT_W-1:0]          count_first_layer;
  logic [ECNT_W-1:0]          count_second_front;
  logic [ECNT_W-1:0]          count_second_back;
  logic [ECNT_W-1:0]          count_scintillator;
  logic                       last_result;

  calib_t            calib_mem [256];
  bit                calib_written [256];
  logic [DCNT_W-1:0] det_fired [LAYERS];
  logic [ECNT_W-1:0] evt_fired [LAYERS];
  zs_result_t        results_due [$];

  int errors         = 0;
  int items_accepted = 0;
  int quiet_cycles   = 0;
  int stall_requests = 0;
  int stalls_served  = 0;
  bit steady         = 1'b0;

  detector_zero_suppress_calibrate_core u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic zs_result_t make_result(kind_t k, logic [1:0] det, logic [1:0] lay,
                                             logic [3:0] ch, logic signed [ENERGY_W-1:0] e,
                                             logic [LAYERS-1:0][ECNT_W-1:0] c);
    zs_result_t r;
    r.kind    = k;
    r.det     = det;
    r.layer   = lay;
    r.channel = ch;
    r.energy  = e;
    r.counts  = c;
    r.last    = 1'b0;
    return r;
  endfunction

  task automatic calibrate_and_count(input sample_item_t it);
    zs_result_t                    batch [$];
    logic [ADDR_W-1:0]             addr;
    calib_t                        entry;
    longint                        sum;
    int                            lay;
    int                            size;
    logic [LAYERS-1:0][ECNT_W-1:0] tally;
    addr = {it.det, it.layer, it.channel};
    lay  = int'(it.layer);
    if (it.op == OP_LOAD) begin
      calib_mem[addr]     = '{intercept: it.icpt, slope: it.slope, cut: it.cut};
      calib_written[addr] = 1'b1;
    end else begin
      size = (it.layer == LAYER_SCINT) ? CRYSTALS : STRIPS;
      if (int'(it.det) < DETECTORS && int'(it.channel) < size) begin
        entry = calib_mem[addr];
        if (it.adc > entry.cut) begin
          if (it.layer == LAYER_SCINT) begin
            sum = longint'({52'd0, it.adc});
          end else begin
            sum = longint'({44'd0, entry.slope}) * longint'({52'd0, it.adc})
                + longint'($signed(entry.intercept));
            if (sum > E_MAX) sum = E_MAX;
            if (sum < E_MIN) sum = E_MIN;
          end
          batch = {batch, make_result(KIND_HIT, it.det, it.layer, it.channel,
                                      sum[ENERGY_W-1:0], '0)};
          if (det_fired[lay] < DCNT_MAX) det_fired[lay]++;
          if (evt_fired[lay] < ECNT_MAX) evt_fired[lay]++;
        end
      end
      if (it.det_last) begin
        for (int i = 0; i < LAYERS; i++) tally[i] = ECNT_W'(det_fired[i]);
        batch = {batch, make_result(KIND_DET, it.det, 2'd0, 4'd0, '0, tally)};
        for (int i = 0; i < LAYERS; i++) det_fired[i] = '0;
      end
      if (it.evt_last) begin
        for (int i = 0; i < LAYERS; i++) tally[i] = evt_fired[i];
        batch = {batch, make_result(KIND_EVT, 2'd0, 2'd0, 4'd0, '0, tally)};
        for (int i = 0; i < LAYERS; i++) begin
          det_fired[i] = '0;
          evt_fired[i] = '0;
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      results_due = {results_due, batch};
    end
  endtask

  task automatic send_item(input sample_item_t it);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        sample_valid <= 1'b0;
        @(posedge clk);
      end
    end
    sample_valid    <= 1'b1;
    operation       <= it.op;
    detector        <= it.det;
    layer           <= it.layer;
    channel         <= it.channel;
    adc_value       <= it.adc;
    cut_value       <= it.cut;
    slope_value     <= it.slope;
    intercept_value <= it.icpt;
    detector_last   <= it.det_last;
    event_last      <= it.evt_last;
    do @(posedge clk); while (!sample_ready);
    items_accepted++;
    calibrate_and_count(it);
  endtask

  task automatic load_entry(input logic [1:0] det, input layer_t lay, input logic [3:0] ch,
                            input logic [CUT_W-1:0] cut, input logic [SLOPE_W-1:0] slope,
                            input logic [ICPT_W-1:0] icpt);
    sample_item_t it;
    it.op       = OP_LOAD;
    it.det      = det;
    it.layer    = lay;
    it.channel  = ch;
    it.adc      = ADC_W'($urandom);
    it.cut      = cut;
    it.slope    = slope;
    it.icpt     = icpt;
    it.det_last = 1'($urandom_range(1));
    it.evt_last = 1'($urandom_range(1));
    send_item(it);
  endtask

  task automatic load_random(input logic [1:0] det, input layer_t lay, input logic [3:0] ch);
    logic [CUT_W-1:0] cut;
    int               roll;
    roll = $urandom_range(99);
    if (roll < 60)      cut = CUT_W'($urandom_range(1023));
    else if (roll < 90) cut = CUT_W'($urandom);
    else                cut = {CUT_W{1'b1}};
    load_entry(det, lay, ch, cut, SLOPE_W'($urandom), ICPT_W'($urandom));
  endtask

  task automatic send_sample(input logic [1:0] det, input layer_t lay, input logic [3:0] ch,
                             input logic [ADC_W-1:0] adc, input logic dl, input logic el);
    sample_item_t it;
    if (!calib_written[{det, lay, ch}]) load_random(det, lay, ch);
    it.op       = OP_SAMPLE;
    it.det      = det;
    it.layer    = lay;
    it.channel  = ch;
    it.adc      = adc;
    it.cut      = CUT_W'($urandom);
    it.slope    = SLOPE_W'($urandom);
    it.icpt     = ICPT_W'($urandom);
    it.det_last = dl;
    it.evt_last = el;
    send_item(it);
  endtask

  function automatic logic [3:0] pick_channel(layer_t lay);
    if (lay == LAYER_SCINT) begin
      if ($urandom_range(9) == 0) return 4'($urandom_range(15, CRYSTALS));
      return 4'($urandom_range(CRYSTALS - 1));
    end
    return 4'($urandom_range(STRIPS - 1));
  endfunction

  task automatic test_calibration_loads();
    load_entry(2'd0, LAYER_FIRST, 4'd0,  12'd0,    20'hFFFFF, 32'h7FFF_FFFF);
    load_entry(2'd1, LAYER_FRONT, 4'd15, 12'hFFF,  20'd0,     32'd0);
    load_entry(2'd2, LAYER_BACK,  4'd7,  12'd100,  20'd0,     32'h8000_0000);
    load_entry(2'd1, LAYER_FIRST, 4'd3,  12'hFFE,  20'h10000, 32'hFFFF_FFFB);
    load_entry(2'd3, LAYER_SCINT, 4'd8,  12'd0,    20'hABCDE, 32'h1234_5678);
    load_entry(2'd3, LAYER_SCINT, 4'd15, 12'd0,    20'h12345, 32'h5555_AAAA);
    load_entry(2'd0, LAYER_SCINT, 4'd9,  12'd0,    20'h54321, 32'hAAAA_5555);
  endtask

  task automatic test_directed_samples();
    // A value equal to the threshold must not fire.
    send_sample(2'd0, LAYER_FIRST, 4'd0,  12'd0,   1'b0, 1'b0);
    send_sample(2'd0, LAYER_FIRST, 4'd0,  12'hFFF, 1'b0, 1'b0);
    send_sample(2'd1, LAYER_FRONT, 4'd15, 12'hFFF, 1'b0, 1'b0);
    send_sample(2'd2, LAYER_BACK,  4'd7,  12'd100, 1'b0, 1'b0);
    send_sample(2'd2, LAYER_BACK,  4'd7,  12'd101, 1'b0, 1'b0);
    send_sample(2'd1, LAYER_FIRST, 4'd3,  12'hFFF, 1'b0, 1'b0);
    send_sample(2'd3, LAYER_SCINT, 4'd8,  12'hFFF, 1'b1, 1'b0);
    // Crystals past the last one give no hit, but their markers still count.
    send_sample(2'd3, LAYER_SCINT, 4'd15, 12'hFFF, 1'b1, 1'b0);
    send_sample(2'd0, LAYER_SCINT, 4'd9,  12'd1,   1'b0, 1'b1);
    send_sample(2'd0, LAYER_FIRST, 4'd0,  12'h800, 1'b1, 1'b1);
    send_sample(2'd2, LAYER_BACK,  4'd7,  12'd0,   1'b0, 1'b1);
    send_sample(2'd1, LAYER_FRONT, 4'd15, 12'd0,   1'b1, 1'b0);
  endtask

  task automatic test_count_saturation();
    // This test also serves as the stretch without any idle cycles.
    steady = 1'b1;
    load_entry(2'd2, LAYER_FRONT, 4'd5, 12'd0, SLOPE_W'($urandom), ICPT_W'($urandom));
    for (int i = 0; i < 140; i++)
      send_sample(2'd2, LAYER_FRONT, 4'd5, 12'($urandom_range(4095, 1)),
                  (i % 45) == 44, i == 139);
    steady = 1'b0;
  endtask

  task automatic test_result_backpressure();
    layer_t lay;
    stall_requests++;
    for (int i = 0; i < 30; i++) begin
      lay = layer_t'($urandom_range(3));
      send_sample(2'($urandom_range(3)), lay, pick_channel(lay), 12'($urandom),
                  (i % 3) == 2, (i % 10) == 9);
    end
  endtask

  task automatic test_random_events();
    int         stop_at;
    int         roll;
    int         n_det;
    int         n_samp;
    logic [1:0] det;
    layer_t     lay;
    stop_at = items_accepted + RANDOM_ITEMS;
    while (items_accepted < stop_at) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        lay = layer_t'($urandom_range(3));
        send_sample(2'($urandom), lay, 4'($urandom), 12'($urandom),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (roll < 14) begin
        load_random(2'($urandom), layer_t'($urandom_range(3)), 4'($urandom));
      end else begin
        n_det = $urandom_range(4, 1);
        for (int d = 0; d < n_det; d++) begin
          det    = 2'($urandom);
          n_samp = $urandom_range(6, 1);
          for (int s = 0; s < n_samp; s++) begin
            lay = layer_t'($urandom_range(3));
            send_sample(det, lay, pick_channel(lay), 12'($urandom),
                        s == n_samp - 1, (s == n_samp - 1) && (d == n_det - 1));
          end
        end
      end
    end
  endtask

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    zs_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (results_due.size() == 0) begin
        $error("result of kind %0d arrived with none expected", kind);
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("kind", want.kind, kind);
        check_field("hit_detector", want.det, hit_detector);
        check_field("hit_layer", want.layer, hit_layer);
        check_field("hit_channel", want.channel, hit_channel);
        check_field("energy", longint'(want.energy), longint'(energy));
        check_field("count_first_layer", want.counts[0], count_first_layer);
        check_field("count_second_front", want.counts[1], count_second_front);
        check_field("count_second_back", want.counts[2], count_second_back);
        check_field("count_scintillator", want.counts[3], count_scintillator);
        check_field("last_result", want.last, last_result);
      end
    end
  end

  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_served != stall_requests) begin
        stalls_served++;
        result_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (result_valid && result_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    sample_valid    = 1'b0;
    operation       = OP_LOAD;
    detector        = '0;
    layer           = '0;
    channel         = '0;
    adc_value       = '0;
    cut_value       = '0;
    slope_value     = '0;
    intercept_value = '0;
    detector_last   = 1'b0;
    event_last      = 1'b0;
    for (int i = 0; i < LAYERS; i++) begin
      det_fired[i] = '0;
      evt_fired[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_calibration_loads();
    test_directed_samples();
    test_count_saturation();
    test_result_backpressure();
    test_random_events();

    sample_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
